// ===== hw/rtl/source_byte_tokenizer_macros.svh =====
// assertion macros for the source byte tokenizer
`ifndef SOURCE_BYTE_TOKENIZER_MACROS_SVH
`define SOURCE_BYTE_TOKENIZER_MACROS_SVH
`ifndef SYNTH
`define SBT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SBT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SBT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/sbt_pkg.sv =====
// shared types, constants and functions of the source byte tokenizer
package sbt_pkg;

    localparam int POSITION_BITS = 32;
    localparam int KEYWORD_MAX_BYTES = 8;
    localparam int FILL_BITS = $clog2(KEYWORD_MAX_BYTES + 2);
    localparam int KW_COUNT = 33;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    localparam logic [6:0] K_IDENT = 7'd33;
    localparam logic [6:0] K_NUMBER = 7'd34;
    localparam logic [6:0] K_STRING = 7'd35;
    localparam logic [6:0] K_CHAR = 7'd36;
    localparam logic [6:0] K_INVALID = 7'd71;
    localparam logic [6:0] K_EOF = 7'd72;
    localparam logic [6:0] K_NONE = 7'd127;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_BIN = 2'd2;

    typedef enum logic [10:0] {
        M_IDLE  = 11'b00000000001,
        M_IDENT = 11'b00000000010,
        M_ZERO  = 11'b00000000100,
        M_NUM   = 11'b00000001000,
        M_STR   = 11'b00000010000,
        M_ESC   = 11'b00000100000,
        M_OP    = 11'b00001000000,
        M_LINE  = 11'b00010000000,
        M_BLOCK = 11'b00100000000,
        M_BSTAR = 11'b01000000000,
        M_DEAD  = 11'b10000000000
    } mode_t;

    typedef struct packed {
        logic [6:0]  kind;
        logic [31:0] offset;
        logic [31:0] length;
        logic [63:0] value;
        logic [31:0] line;
        logic [31:0] column;
    } token_t;

    typedef struct packed {
        logic   valid0;
        logic   valid1;
        token_t tok0;
        token_t tok1;
    } token_pair_t;

    typedef logic [KEYWORD_MAX_BYTES*8-1:0] prefix_t;

    function automatic logic [63:0] kw_text(input int i);
        case (i)
            0: kw_text = "fn";       1: kw_text = "let";     2: kw_text = "const";
            3: kw_text = "static";   4: kw_text = "extern";  5: kw_text = "inline";
            6: kw_text = "unsafe";   7: kw_text = "volatile"; 8: kw_text = "struct";
            9: kw_text = "enum";     10: kw_text = "return"; 11: kw_text = "kernel";
            12: kw_text = "spec";    13: kw_text = "target"; 14: kw_text = "abi";
            15: kw_text = "section"; 16: kw_text = "asm";    17: kw_text = "if";
            18: kw_text = "while";   19: kw_text = "true";   20: kw_text = "false";
            21: kw_text = "void";    22: kw_text = "bool";   23: kw_text = "u8";
            24: kw_text = "u16";     25: kw_text = "u32";    26: kw_text = "u64";
            27: kw_text = "i8";      28: kw_text = "i16";    29: kw_text = "i32";
            30: kw_text = "i64";     31: kw_text = "usize";  32: kw_text = "isize";
            default: kw_text = '0;
        endcase
    endfunction

    function automatic int kw_len(input int i);
        logic [63:0] t;
        int n;
        t = kw_text(i);
        n = 0;
        for (int b = 0; b < 8; b++)
        begin
            if (t[b*8 +: 8] != 8'd0)
            begin
                n = b + 1;
            end
        end
        kw_len = n;
    endfunction

    // prefix holds the first byte in the low lane, unused lanes zero
    function automatic logic [6:0] ident_kind(input prefix_t pfx,
                                              input logic [FILL_BITS-1:0] fill);
        logic [6:0] k;
        logic [63:0] t;
        prefix_t want;
        int n;
        k = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            t = kw_text(i);
            n = kw_len(i);
            want = '0;
            for (int b = 0; b < 8; b++)
            begin
                if (b < n)
                begin
                    want[b*8 +: 8] = t[(n-1-b)*8 +: 8];
                end
            end
            if (fill == FILL_BITS'(n) && pfx == want)
            begin
                k = 7'(i);
            end
        end
        ident_kind = k;
    endfunction

    function automatic logic [6:0] single_kind(input logic [7:0] c);
        case (c)
            "(": single_kind = 7'd37;  ")": single_kind = 7'd38;
            "{": single_kind = 7'd39;  "}": single_kind = 7'd40;
            "[": single_kind = 7'd41;  "]": single_kind = 7'd42;
            ",": single_kind = 7'd45;  ";": single_kind = 7'd46;
            ".": single_kind = 7'd47;  "@": single_kind = 7'd48;
            "*": single_kind = 7'd54;  "%": single_kind = 7'd56;
            "^": single_kind = 7'd61;  "~": single_kind = 7'd62;
            default: single_kind = K_NONE;
        endcase
    endfunction

    function automatic logic [6:0] held_kind(input logic [7:0] c);
        case (c)
            ":": held_kind = 7'd44;  "+": held_kind = 7'd50;
            "-": held_kind = 7'd53;  "/": held_kind = 7'd55;
            "&": held_kind = 7'd58;  "|": held_kind = 7'd60;
            "!": held_kind = 7'd64;  "=": held_kind = 7'd66;
            "<": held_kind = 7'd68;  ">": held_kind = 7'd70;
            default: held_kind = K_NONE;
        endcase
    endfunction

    function automatic logic [6:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
        pair_kind = K_NONE;
        if (p == ":" && c == ":") pair_kind = 7'd43;
        if (p == "+" && c == "=") pair_kind = 7'd49;
        if (p == "-" && c == ">") pair_kind = 7'd51;
        if (p == "-" && c == "=") pair_kind = 7'd52;
        if (p == "&" && c == "&") pair_kind = 7'd57;
        if (p == "|" && c == "|") pair_kind = 7'd59;
        if (p == "!" && c == "=") pair_kind = 7'd63;
        if (p == "=" && c == "=") pair_kind = 7'd65;
        if (p == "<" && c == "=") pair_kind = 7'd67;
        if (p == ">" && c == "=") pair_kind = 7'd69;
    endfunction

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        sat_inc = (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [31:0] low32(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS+31:0] w;
        w = {{32{1'b0}}, v};
        low32 = w[31:0];
    endfunction

endpackage

// ===== hw/rtl/sbt_scanner.sv =====
// scanner core: mode register, position counters and token formation
module sbt_scanner
    import sbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    output token_pair_t tokens
);

    mode_t mode_reg, mode_next;
    logic [POSITION_BITS-1:0] off_reg, off_next, line_reg, line_next, col_reg, col_next;
    logic [POSITION_BITS-1:0] soff_reg, soff_next, sline_reg, sline_next;
    logic [POSITION_BITS-1:0] scol_reg, scol_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  base_reg, base_next;
    prefix_t     pfx_reg, pfx_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic [7:0]  pend_reg, pend_next;
    logic        dq_reg, dq_next;

    logic        c_space, c_alpha, c_digit, c_ident;
    logic [3:0]  digit;
    logic        digit_ok;
    logic [6:0]  held_c, single_c, pair_c;
    logic [6:0]  id_kind;
    logic [POSITION_BITS-1:0] tok_len;
    logic [63:0] acc_scaled;

    always_comb
    begin
        c_space = (in_byte == " ") || (in_byte >= 8'd9 && in_byte <= 8'd13);
        c_alpha = (in_byte >= "a" && in_byte <= "z") || (in_byte >= "A" && in_byte <= "Z");
        c_digit = in_byte >= "0" && in_byte <= "9";
        c_ident = c_alpha || c_digit || in_byte == "_";
        held_c = held_kind(in_byte);
        single_c = single_kind(in_byte);
        pair_c = pair_kind(pend_reg, in_byte);
        id_kind = ident_kind(pfx_reg, fill_reg);
        tok_len = off_reg - soff_reg;
        digit = 4'd0;
        digit_ok = 1'b0;
        if (c_digit)
        begin
            digit = 4'(in_byte - "0");
            digit_ok = (base_reg != BASE_BIN) || (in_byte <= "1");
        end
        else if (base_reg == BASE_HEX && in_byte >= "a" && in_byte <= "f")
        begin
            digit = 4'(in_byte - "a" + 8'd10);
            digit_ok = 1'b1;
        end
        else if (base_reg == BASE_HEX && in_byte >= "A" && in_byte <= "F")
        begin
            digit = 4'(in_byte - "A" + 8'd10);
            digit_ok = 1'b1;
        end
        // scale the accumulator by the base: shifts for hex and binary, times ten as shifts and one add
        case (base_reg)
            BASE_HEX: acc_scaled = {acc_reg[59:0], 4'd0};
            BASE_BIN: acc_scaled = {acc_reg[62:0], 1'b0};
            default:  acc_scaled = {acc_reg[60:0], 3'd0} + {acc_reg[62:0], 1'b0};
        endcase
    end

    always_comb
    begin
        logic        restart;
        logic        adv;
        token_t      t;
        mode_next = mode_reg;
        off_next = off_reg; line_next = line_reg; col_next = col_reg;
        soff_next = soff_reg; sline_next = sline_reg; scol_next = scol_reg;
        acc_next = acc_reg; base_next = base_reg; pfx_next = pfx_reg;
        fill_next = fill_reg; pend_next = pend_reg; dq_next = dq_reg;
        tokens = '0;
        restart = 1'b0;
        adv = 1'b0;
        t.kind = K_NONE;
        t.offset = low32(soff_reg);
        t.length = low32(tok_len);
        t.value = 64'd0;
        t.line = low32(sline_reg);
        t.column = low32(scol_reg);

        if (end_of_input)
        begin
            // held token first, then eof
            case (mode_reg)
                M_IDENT: t.kind = id_kind;
                M_ZERO, M_NUM:
                begin
                    t.kind = K_NUMBER;
                    t.value = acc_reg;
                end
                M_STR, M_ESC: t.kind = dq_reg ? K_STRING : K_CHAR;
                M_OP: t.kind = held_kind(pend_reg);
                default: t.kind = K_NONE;
            endcase
            tokens.valid0 = t.kind != K_NONE;
            tokens.tok0 = t;
            tokens.valid1 = 1'b1;
            tokens.tok1.kind = K_EOF;
            tokens.tok1.offset = low32(off_reg);
            tokens.tok1.length = 32'd0;
            tokens.tok1.value = 64'd0;
            tokens.tok1.line = low32(line_reg);
            tokens.tok1.column = low32(col_reg);
            mode_next = M_IDLE;
            off_next = '0; line_next = POSITION_BITS'(1); col_next = POSITION_BITS'(1);
            soff_next = '0; sline_next = POSITION_BITS'(1); scol_next = POSITION_BITS'(1);
            acc_next = '0; base_next = BASE_DEC; pfx_next = '0; fill_next = '0;
            pend_next = '0; dq_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                M_IDLE: restart = 1'b1;
                M_IDENT:
                begin
                    if (c_ident)
                    begin
                        if (fill_reg < FILL_BITS'(KEYWORD_MAX_BYTES))
                        begin
                            pfx_next[fill_reg[FILL_BITS-2:0]*8 +: 8] = in_byte;
                        end
                        if (fill_reg <= FILL_BITS'(KEYWORD_MAX_BYTES))
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        adv = 1'b1;
                    end
                    else
                    begin
                        t.kind = id_kind;
                        restart = 1'b1;
                    end
                end
                M_ZERO, M_NUM:
                begin
                    if (mode_reg == M_ZERO && (in_byte == "x" || in_byte == "X"
                        || in_byte == "b" || in_byte == "B"))
                    begin
                        base_next = (in_byte == "x" || in_byte == "X") ? BASE_HEX : BASE_BIN;
                        acc_next = '0;
                        adv = 1'b1;
                        mode_next = M_NUM;
                    end
                    else if (digit_ok)
                    begin
                        acc_next = acc_scaled + {60'd0, digit};
                        adv = 1'b1;
                        mode_next = M_NUM;
                    end
                    else
                    begin
                        t.kind = K_NUMBER;
                        t.value = acc_reg;
                        restart = 1'b1;
                    end
                end
                M_STR:
                begin
                    adv = 1'b1;
                    if (in_byte == (dq_reg ? 8'h22 : 8'h27))
                    begin
                        t.kind = dq_reg ? K_STRING : K_CHAR;
                        t.length = low32(sat_inc(off_reg) - soff_reg);
                        mode_next = M_IDLE;
                    end
                    else if (in_byte == 8'h5c)
                    begin
                        mode_next = M_ESC;
                    end
                end
                M_ESC:
                begin
                    adv = 1'b1;
                    mode_next = M_STR;
                end
                M_OP:
                begin
                    if (pend_reg == "/" && (in_byte == "/" || in_byte == "*"))
                    begin
                        adv = 1'b1;
                        mode_next = (in_byte == "/") ? M_LINE : M_BLOCK;
                    end
                    else if (pair_c != K_NONE)
                    begin
                        adv = 1'b1;
                        t.kind = pair_c;
                        t.length = low32(sat_inc(off_reg) - soff_reg);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        t.kind = held_kind(pend_reg);
                        restart = 1'b1;
                    end
                end
                M_LINE:
                begin
                    adv = 1'b1;
                    if (in_byte == 8'h0a) mode_next = M_IDLE;
                end
                M_BLOCK:
                begin
                    adv = 1'b1;
                    if (in_byte == "*") mode_next = M_BSTAR;
                end
                M_BSTAR:
                begin
                    adv = 1'b1;
                    if (in_byte == "/") mode_next = M_IDLE;
                    else if (in_byte != "*") mode_next = M_BLOCK;
                end
                default: adv = 1'b0;
            endcase
            tokens.valid0 = t.kind != K_NONE;
            tokens.tok0 = t;

            if (restart)
            begin
                // a new token opens at the current position unless the byte is white space
                adv = 1'b1;
                mode_next = M_IDLE;
                tokens.tok1.offset = low32(off_reg);
                tokens.tok1.line = low32(line_reg);
                tokens.tok1.column = low32(col_reg);
                tokens.tok1.length = low32(sat_inc(off_reg) - off_reg);
                tokens.tok1.value = 64'd0;
                tokens.tok1.kind = K_NONE;
                if (!c_space)
                begin
                    soff_next = off_reg; sline_next = line_reg; scol_next = col_reg;
                    if (c_alpha || in_byte == "_")
                    begin
                        pfx_next = '0;
                        pfx_next[7:0] = in_byte;
                        fill_next = FILL_BITS'(1);
                        mode_next = M_IDENT;
                    end
                    else if (c_digit)
                    begin
                        acc_next = {60'd0, in_byte[3:0]};
                        base_next = BASE_DEC;
                        mode_next = (in_byte == "0") ? M_ZERO : M_NUM;
                    end
                    else if (in_byte == 8'h22 || in_byte == 8'h27)
                    begin
                        dq_next = in_byte == 8'h22;
                        mode_next = M_STR;
                    end
                    else if (held_c != K_NONE)
                    begin
                        pend_next = in_byte;
                        mode_next = M_OP;
                    end
                    else if (single_c != K_NONE)
                    begin
                        tokens.tok1.kind = single_c;
                    end
                    else
                    begin
                        tokens.tok1.kind = K_INVALID;
                        mode_next = M_DEAD;
                    end
                end
                tokens.valid1 = tokens.tok1.kind != K_NONE;
            end

            if (adv)
            begin
                off_next = sat_inc(off_reg);
                if (in_byte == 8'h0a)
                begin
                    line_next = sat_inc(line_reg);
                    col_next = POSITION_BITS'(1);
                end
                else
                begin
                    col_next = sat_inc(col_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            off_reg <= '0; line_reg <= POSITION_BITS'(1); col_reg <= POSITION_BITS'(1);
            soff_reg <= '0; sline_reg <= POSITION_BITS'(1); scol_reg <= POSITION_BITS'(1);
            acc_reg <= '0; base_reg <= BASE_DEC; pfx_reg <= '0; fill_reg <= '0;
            pend_reg <= '0; dq_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            off_reg <= off_next; line_reg <= line_next; col_reg <= col_next;
            soff_reg <= soff_next; sline_reg <= sline_next; scol_reg <= scol_next;
            acc_reg <= acc_next; base_reg <= base_next; pfx_reg <= pfx_next;
            fill_reg <= fill_next; pend_reg <= pend_next; dq_reg <= dq_next;
        end
    end

endmodule

// ===== hw/rtl/sbt_out_queue.sv =====
// result queue: takes up to two tokens per request, holds up to four and hands them out in order
module sbt_out_queue
    import sbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  token_pair_t pair,
    output logic        can_push,
    output logic        tvalid,
    input  logic        tready,
    output token_t      tok,
    output logic        tlast
);

    `include "source_byte_tokenizer_macros.svh"

    token_t slot_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic [3:0] last_reg;
    logic       pop;
    logic [1:0] n_in;

    assign tvalid = cnt_reg != 3'd0;
    assign tok = slot_reg[rd_reg];
    assign tlast = last_reg[rd_reg];
    assign pop = tvalid && tready;
    // two free slots needed for a request that may bring two tokens
    assign can_push = cnt_reg <= 3'd2;
    assign n_in = push ? (2'(pair.valid0) + 2'(pair.valid1)) : 2'd0;

    always_ff @(posedge clk)
    begin
        if (push && pair.valid0)
        begin
            slot_reg[wr_reg] <= pair.tok0;
        end
        if (push && pair.valid1)
        begin
            slot_reg[wr_reg + 2'(pair.valid0)] <= pair.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            if (push && pair.valid0)
            begin
                last_reg[wr_reg] <= !pair.valid1;
            end
            if (push && pair.valid1)
            begin
                last_reg[wr_reg + 2'(pair.valid0)] <= 1'b1;
            end
            wr_reg <= wr_reg + n_in;
            rd_reg <= rd_reg + 2'(pop);
            cnt_reg <= cnt_reg + 3'(n_in) - 3'(pop);
        end
    end

    `SBT_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, cnt_reg <= 3'd2)
    `SBT_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, cnt_reg <= 3'd4)
    `SBT_ASSERT_NEXT(a_stall_holds, clk, rst_n, tvalid && !tready, tvalid && $stable(tok))

endmodule

// ===== hw/rtl/source_byte_tokenizer.sv =====
// top level of the source byte tokenizer
// Streaming lexical scanner: one source byte (or an end marker) per request on the
// s_axis side, tokens on the m_axis side. A byte is taken every cycle while the
// four-entry result queue has room for two tokens; the scanner decides the whole
// byte combinationally, so the rate is one byte per clock while there is room, and
// a request's tokens are registered in the queue. Throughput is bounded only by the
// output side, since one request can give two tokens (a held token plus the next
// one, or a held token plus eof). tlast marks the final token of a request.
module source_byte_tokenizer
    import sbt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // in_byte
    input  logic         s_axis_tuser,   // end_of_input
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [199:0] m_axis_tdata,   // token_kind, start_offset, token_length,
                                         // number_value, start_line, start_column, pad
    output logic         m_axis_tlast    // last_of_run
);

    token_pair_t pair;
    token_t      tok;
    logic        step;

    assign step = s_axis_tvalid && s_axis_tready;

    sbt_scanner u_scanner (
        .clk(clk), .rst_n(rst_n), .step(step),
        .in_byte(s_axis_tdata), .end_of_input(s_axis_tuser), .tokens(pair)
    );

    sbt_out_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(step), .pair(pair), .can_push(s_axis_tready),
        .tvalid(m_axis_tvalid), .tready(m_axis_tready), .tok(tok), .tlast(m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, tok.column, tok.line, tok.value, tok.length,
                           tok.offset, tok.kind};

endmodule
